>>> design/assert_macros.svh
// Assertion helpers; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned RadiusW = 9;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned PointW  = 12;
  localparam int unsigned ErrW    = 14;
  localparam int unsigned IdxW    = 3;

  localparam int unsigned ScreenWidthDef  = 240;
  localparam int unsigned ScreenHeightDef = 240;

  localparam int unsigned ErrInit    = 3;
  localparam int unsigned ErrIncLow  = 6;
  localparam int unsigned ErrIncHigh = 10;

  localparam logic FuncStart   = 1'b0;
  localparam logic FuncAdvance = 1'b1;

  localparam logic [IdxW-1:0] PointLast = IdxW'(7);

  typedef struct packed {
    logic              func;
    logic [CoordW-1:0]  center_x;
    logic [CoordW-1:0]  center_y;
    logic [RadiusW-1:0] radius;
    logic              fill_mode;
    logic [ColorW-1:0]  pen_color;
  } cpg_in_t;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic                     visible;
    logic [ColorW-1:0]        point_color;
    logic                     last;
  } cpg_out_t;

endpackage

`default_nettype wire

>>> design/circle_point_generator.sv
// Channel   Dir   Handshake               Beat
// in_       in    in_valid / in_ready     cpg_in_t  (start or advance)
// out_      out   out_valid / out_ready   cpg_out_t (one plotted point)
//
// An advance beat on a live circle yields eight point beats, one per cycle from the
// point register while out_ready holds high; start beats and advances on an idle
// circle yield nothing.
// The next advance is taken in the cycle its predecessor's eighth point is issued.
// rst_n (synchronous) clears the circle state and all valid flags.
// out_ready low holds the point register; in_ready then drops once a job is pending.
`default_nettype none
`include "assert_macros.svh"

module circle_point_generator #(
  parameter int unsigned SCREEN_WIDTH  = cpg_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = cpg_pkg::ScreenHeightDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpg_pkg::cpg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cpg_pkg::cpg_out_t out_data
);
  import cpg_pkg::*;

  localparam logic [PointW-1:0] ScrW = PointW'(SCREEN_WIDTH);
  localparam logic [PointW-1:0] ScrH = PointW'(SCREEN_HEIGHT);

  logic [CoordW-1:0] origin_x_r, origin_y_r, step_x_r, step_y_r, row_counter_r;
  logic [ErrW-1:0]   decision_error_r;
  logic              filled_r, active_r;
  logic [ColorW-1:0] latched_color_r;

  logic [CoordW-1:0] job_cx_r, job_cy_r, job_a_r, job_b_r;
  logic              job_end_r;
  logic [ColorW-1:0] job_color_r;
  logic              job_v_r;
  logic [IdxW-1:0]   job_k_r;

  logic     out_v_r;
  cpg_out_t out_r;
  cpg_out_t point_nxt;

  logic in_fire, is_start, adv_live, out_free, out_load, job_done;

  assign in_fire  = in_valid && in_ready;
  assign is_start = (in_data.func == FuncStart);
  assign adv_live = in_fire && (in_data.func == FuncAdvance) && active_r;
  assign out_free = !out_v_r || out_ready;
  assign out_load = job_v_r && out_free;
  assign job_done = out_load && (job_k_r == PointLast);
  assign in_ready = !job_v_r || job_done;

  logic                     err_neg, row_over, take_step, run_ends, ending;
  logic [CoordW:0]          x_inc;
  logic [CoordW-1:0]        row_inc, y_step;
  logic signed [CoordW+1:0] x_ext, y_ext;
  logic [ErrW-1:0]          x4, y4, err_step;

  always_comb begin
    err_neg   = decision_error_r[ErrW-1];
    x_inc     = {1'b0, step_x_r} + (CoordW+1)'(1);
    x4        = ErrW'({step_x_r, 2'b00});
    y4        = ErrW'({step_y_r, 2'b00});
    err_step  = err_neg ? decision_error_r + x4 + ErrW'(ErrIncLow)
                        : decision_error_r + ErrW'(ErrIncHigh) + x4 - y4;
    y_step    = err_neg ? step_y_r : step_y_r - CoordW'(1);
    x_ext     = $signed({1'b0, x_inc});
    y_ext     = err_neg ? $signed({2'b00, step_y_r})
                        : $signed({2'b00, step_y_r}) - (CoordW+2)'(1);
    run_ends  = x_ext > y_ext;
    row_inc   = row_counter_r + CoordW'(1);
    row_over  = row_inc > step_y_r;
    take_step = filled_r ? row_over : 1'b1;
    ending    = take_step && run_ends;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r       <= '0;
      origin_y_r       <= '0;
      step_x_r         <= '0;
      step_y_r         <= '0;
      row_counter_r    <= '0;
      decision_error_r <= '0;
      filled_r         <= 1'b0;
      active_r         <= 1'b0;
      latched_color_r  <= '0;
    end else if (in_fire) begin
      if (is_start) begin
        origin_x_r       <= in_data.center_x;
        origin_y_r       <= in_data.center_y;
        step_x_r         <= '0;
        step_y_r         <= CoordW'(in_data.radius);
        row_counter_r    <= '0;
        decision_error_r <= ErrW'(ErrInit) - ErrW'({in_data.radius, 1'b0});
        filled_r         <= in_data.fill_mode;
        latched_color_r  <= in_data.pen_color;
        active_r         <= 1'b1;
      end else if (active_r) begin
        if (filled_r) begin
          row_counter_r <= row_over ? x_inc[CoordW-1:0] : row_inc;
        end
        if (take_step) begin
          step_x_r         <= x_inc[CoordW-1:0];
          step_y_r         <= y_step;
          decision_error_r <= err_step;
        end
        if (ending) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      job_k_r <= '0;
    end else if (adv_live) begin
      job_v_r <= 1'b1;
      job_k_r <= '0;
    end else if (out_load) begin
      job_k_r <= job_k_r + IdxW'(1);
      if (job_done) begin
        job_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_live) begin
      job_cx_r    <= origin_x_r;
      job_cy_r    <= origin_y_r;
      job_a_r     <= step_x_r;
      job_b_r     <= filled_r ? row_counter_r : step_y_r;
      job_end_r   <= ending;
      job_color_r <= latched_color_r;
    end
  end

  logic              swap_ab, x_neg, y_neg;
  logic [PointW-1:0] cx, cy, dx, dy, px, py;

  always_comb begin
    unique case (job_k_r)
      3'd0: {swap_ab, x_neg, y_neg} = 3'b000;
      3'd1: {swap_ab, x_neg, y_neg} = 3'b010;
      3'd2: {swap_ab, x_neg, y_neg} = 3'b110;
      3'd3: {swap_ab, x_neg, y_neg} = 3'b111;
      3'd4: {swap_ab, x_neg, y_neg} = 3'b011;
      3'd5: {swap_ab, x_neg, y_neg} = 3'b001;
      3'd6: {swap_ab, x_neg, y_neg} = 3'b101;
      3'd7: {swap_ab, x_neg, y_neg} = 3'b100;
    endcase
    cx = PointW'(job_cx_r);
    cy = PointW'(job_cy_r);
    dx = PointW'(swap_ab ? job_b_r : job_a_r);
    dy = PointW'(swap_ab ? job_a_r : job_b_r);
    px = x_neg ? cx - dx : cx + dx;
    py = y_neg ? cy - dy : cy + dy;
    point_nxt.point_x     = $signed(px);
    point_nxt.point_y     = $signed(py);
    point_nxt.visible     = !px[PointW-1] && (px < ScrW) && !py[PointW-1] && (py < ScrH);
    point_nxt.point_color = job_color_r;
    point_nxt.last        = job_end_r && (job_k_r == PointLast);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= point_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `ASSERT_NEXT(a_last_only_eighth, out_load && (job_k_r != PointLast), !out_r.last, "last on inner point")
  `ASSERT_IMPLY(a_neg_invisible, out_v_r && (out_r.point_x[PointW-1] || out_r.point_y[PointW-1]), !out_r.visible, "negative point visible")
  `ASSERT_NEXT(a_start_arms, in_fire && is_start, active_r, "start did not arm circle")
  `ASSERT_IMPLY(a_x_le_y, active_r, step_x_r <= step_y_r, "live circle past diagonal")
  `ASSERT_IMPLY(a_row_span, active_r && filled_r, (row_counter_r >= step_x_r) && (row_counter_r <= step_y_r), "row counter out of span")

endmodule

`default_nettype wire

>>> tb/tb_circle_point_generator.sv
`timescale 1ns / 1ps

module tb_circle_point_generator;
  import cpg_pkg::*;

  localparam int ScrW = ScreenWidthDef;
  localparam int ScrH = ScreenHeightDef;
  localparam int CycleLimit = 400000;
  localparam int RandItems = 86;

  typedef enum {ByModel, NoPoints, CentreOnly} row_chk_t;

  typedef struct {
    cpg_in_t  beat;
    row_chk_t chk;
    cpg_out_t centre;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cpg_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  cpg_out_t out_data;

  circle_point_generator #(
    .SCREEN_WIDTH (ScrW),
    .SCREEN_HEIGHT(ScrH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  logic [CoordW-1:0]      org_x;
  logic [CoordW-1:0]      org_y;
  logic [CoordW-1:0]      cur_x;
  logic [CoordW-1:0]      cur_y;
  logic [CoordW-1:0]      fill_row;
  logic signed [ErrW-1:0] decision;
  logic                   disc_mode;
  logic                   circle_live;
  logic [ColorW-1:0]      ink;

  cpg_out_t step_points[8];
  cpg_out_t pending_points[$];
  dir_row_t directed_rows[$];

  int  err_count;
  int  cycle_count;
  bit  in_calm;
  bit  out_calm;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("circle_point_generator test failed");
      $finish;
    end
  end

  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic bit midpoint_advance();
    int x;
    int y;
    int e;
    x = cur_x;
    y = cur_y;
    e = decision;
    if (e < 0) begin
      e += 4 * x + ErrIncLow;
    end else begin
      e += ErrIncHigh + 4 * (x - y);
      y -= 1;
    end
    x += 1;
    decision = ErrW'(e);
    cur_x = CoordW'(x);
    cur_y = CoordW'(y);
    return x <= y;
  endfunction

  function automatic int rasterize_beat(cpg_in_t beat);
    int cx;
    int cy;
    int a;
    int b;
    int px[8];
    int py[8];
    bit ending;
    if (beat.func == FuncStart) begin
      org_x = beat.center_x;
      org_y = beat.center_y;
      disc_mode = beat.fill_mode;
      ink = beat.pen_color;
      cur_x = '0;
      cur_y = CoordW'(beat.radius);
      fill_row = '0;
      decision = ErrW'(int'(ErrInit) - 2 * int'(beat.radius));
      circle_live = 1'b1;
      return 0;
    end
    if (!circle_live) return 0;
    cx = org_x;
    cy = org_y;
    a = cur_x;
    b = disc_mode ? int'(fill_row) : int'(cur_y);
    ending = 1'b0;
    if (disc_mode) begin
      fill_row = fill_row + 1'b1;
      if (int'(fill_row) > int'(cur_y)) begin
        if (!midpoint_advance()) ending = 1'b1;
        fill_row = cur_x;
      end
    end else if (!midpoint_advance()) begin
      ending = 1'b1;
    end
    if (ending) circle_live = 1'b0;
    px = '{cx + a, cx - a, cx - b, cx - b, cx - a, cx + a, cx + b, cx + b};
    py = '{cy + b, cy + b, cy + a, cy - a, cy - b, cy - b, cy - a, cy + a};
    for (int k = 0; k < 8; k++) begin
      step_points[k].point_x = PointW'(px[k]);
      step_points[k].point_y = PointW'(py[k]);
      step_points[k].visible = px[k] >= 0 && px[k] < ScrW && py[k] >= 0 && py[k] < ScrH;
      step_points[k].point_color = ink;
      step_points[k].last = (k == 7) && ending;
    end
    return 8;
  endfunction

  function automatic void add_row(logic func, int cx, int cy, int r, logic fill, int color,
                                  row_chk_t chk, logic vis);
    dir_row_t row;
    row.beat.func = func;
    row.beat.center_x = CoordW'(cx);
    row.beat.center_y = CoordW'(cy);
    row.beat.radius = RadiusW'(r);
    row.beat.fill_mode = fill;
    row.beat.pen_color = ColorW'(color);
    row.chk = chk;
    row.centre.point_x = PointW'(cx);
    row.centre.point_y = PointW'(cy);
    row.centre.visible = vis;
    row.centre.point_color = ColorW'(color);
    row.centre.last = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic cpg_in_t rand_beat(logic func);
    cpg_in_t beat;
    beat.func = func;
    beat.center_x = CoordW'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 260));
    beat.center_y = CoordW'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 260));
    beat.radius = RadiusW'($urandom_range(0, 511));
    beat.fill_mode = 1'($urandom_range(0, 1));
    beat.pen_color = ColorW'($urandom_range(0, 65535));
    return beat;
  endfunction

  task automatic drive_beat(input cpg_in_t beat, input row_chk_t chk, input cpg_out_t centre,
                            output bit counted);
    int gap;
    int npts;
    cpg_out_t p;
    gap = pick_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    counted = (beat.func == FuncStart) || circle_live;
    npts = rasterize_beat(beat);
    case (chk)
      ByModel: begin
        for (int k = 0; k < npts; k++) pending_points.push_back(step_points[k]);
      end
      CentreOnly: begin
        for (int k = 0; k < 8; k++) begin
          p = centre;
          p.last = (k == 7);
          pending_points.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_point(input cpg_out_t got);
    cpg_out_t want;
    if (pending_points.size() == 0) begin
      $error("unexpected point x=%0d y=%0d", got.point_x, got.point_y);
      err_count++;
      return;
    end
    want = pending_points.pop_front();
    if (got.point_x !== want.point_x) begin
      $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
      err_count++;
    end
    if (got.point_y !== want.point_y) begin
      $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
      err_count++;
    end
    if (got.visible !== want.visible) begin
      $error("visible: expected %0b, got %0b", want.visible, got.visible);
      err_count++;
    end
    if (got.point_color !== want.point_color) begin
      $error("point_color: expected %h, got %h", want.point_color, got.point_color);
      err_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      err_count++;
    end
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = pick_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_point(out_data);
    end
  end

  initial begin
    int rand_items;
    int sel;
    int nadv;
    bit counted;
    cpg_in_t beat;
    cpg_out_t none;
    in_calm = 1'b0;
    none = '0;
    void'(rasterize_beat('0));
    org_x = '0;
    org_y = '0;
    cur_x = '0;
    cur_y = '0;
    fill_row = '0;
    decision = '0;
    disc_mode = 1'b0;
    circle_live = 1'b0;
    ink = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;

    add_row(FuncAdvance, 0, 0, 0, 1'b0, 'h0000, NoPoints, 1'b0);
    add_row(FuncStart, 0, 0, 0, 1'b0, 'hFFFF, NoPoints, 1'b0);
    add_row(FuncAdvance, 0, 0, 0, 1'b0, 'hFFFF, CentreOnly, 1'b1);
    add_row(FuncAdvance, 0, 0, 0, 1'b0, 'hFFFF, NoPoints, 1'b0);
    add_row(FuncStart, 1023, 1023, 0, 1'b1, 'h0000, NoPoints, 1'b0);
    add_row(FuncAdvance, 1023, 1023, 0, 1'b1, 'h0000, CentreOnly, 1'b0);
    add_row(FuncStart, 239, 0, 0, 1'b0, 'h5555, NoPoints, 1'b0);
    add_row(FuncAdvance, 239, 0, 0, 1'b0, 'h5555, CentreOnly, 1'b1);
    add_row(FuncStart, 240, 239, 0, 1'b1, 'hAAAA, NoPoints, 1'b0);
    add_row(FuncAdvance, 240, 239, 0, 1'b1, 'hAAAA, CentreOnly, 1'b0);
    add_row(FuncStart, 512, 512, 511, 1'b0, 'hF0F0, ByModel, 1'b0);
    repeat (3) add_row(FuncAdvance, 0, 0, 0, 1'b0, 'h0000, ByModel, 1'b0);
    add_row(FuncStart, 0, 1023, 511, 1'b1, 'h0F0F, ByModel, 1'b0);
    repeat (3) add_row(FuncAdvance, 1023, 0, 511, 1'b1, 'hFFFF, ByModel, 1'b0);
    add_row(FuncStart, 120, 120, 5, 1'b0, 'h1234, ByModel, 1'b0);
    repeat (5) add_row(FuncAdvance, 0, 0, 0, 1'b0, 'h0000, ByModel, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].beat, directed_rows[i].chk, directed_rows[i].centre, counted);

    rand_items = 0;
    while (rand_items < RandItems) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        beat = rand_beat(FuncStart);
        beat.radius = RadiusW'(beat.fill_mode ? $urandom_range(0, 6) : $urandom_range(0, 20));
        drive_beat(beat, ByModel, none, counted);
        rand_items += counted;
        nadv = 0;
        while (circle_live && nadv < 40) begin
          drive_beat(rand_beat(FuncAdvance), ByModel, none, counted);
          rand_items += counted;
          nadv++;
        end
      end else if (sel < 9) begin
        drive_beat(rand_beat(FuncStart), ByModel, none, counted);
        rand_items += counted;
        repeat ($urandom_range(1, 6)) begin
          drive_beat(rand_beat(FuncAdvance), ByModel, none, counted);
          rand_items += counted;
        end
      end else begin
        drive_beat(rand_beat(1'($urandom_range(0, 1))), ByModel, none, counted);
        rand_items += counted;
      end
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (err_count == 0) begin
      $display("circle_point_generator test passed");
    end else begin
      $display("circle_point_generator test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/cpg_pkg.sv
design/circle_point_generator.sv
tb/tb_circle_point_generator.sv
